>>> rtl/bfss_pkg.sv
// ----------------------------------------------------------------------------
// bfss_pkg
// Shared types and constants for the bounded FIFO server scheduler.
// ----------------------------------------------------------------------------
package bfss_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int LEN_W   = 32;
    localparam int TAG_W   = 16;
    localparam int FIN_W   = 48;
    localparam int LIMIT_W = 6;

    // Stream and register port widths.
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 64;
    localparam int APB_A_W  = 3;
    localparam int APB_D_W  = 32;

    // Register byte addresses.
    localparam logic [APB_A_W-1:0] ADDR_QUEUE_LIMIT = 3'd0;

    // Reset value of the queue limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(QUEUE_DEPTH);

    // Largest representable finish tick.
    localparam logic [FIN_W-1:0] FIN_MAX = {FIN_W{1'b1}};

    // One queued task as stored in the queue memory.
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] arrival;
    } entry_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RETIRE,
        ST_NEW,
        ST_FLUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic retire;
        logic start_new;
        logic enqueue;
        logic drop;
        logic flush;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic head_due;
        logic new_ok;
        logic room;
        logic emit_ok;
        logic hold_valid;
        logic fin;
    } dp_status_t;

endpackage

>>> rtl/bfss_ctrl.sv
// ----------------------------------------------------------------------------
// bfss_ctrl
// Sequencer that walks one task item through retire, admit and drain steps.
// ----------------------------------------------------------------------------
module bfss_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bfss_pkg::dp_status_t status,
    output bfss_pkg::ctrl_cmd_t  cmd
);
    import bfss_pkg::*;

    state_t state_reg, state_next;
    logic   drain_reg, drain_next;
    logic   new_emits;
    logic   new_go;

    // The new task produces a result when it starts at once or is dropped.
    assign new_emits = status.new_ok || !status.room;
    assign new_go    = !new_emits || status.emit_ok;

    // State and drain flag registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            ST_IDLE: begin
                drain_next = 1'b0;
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!status.count_zero && (drain_reg || status.head_due)) begin
                    state_next = ST_RETIRE;
                end else if (drain_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_NEW;
                end
            end
            ST_RETIRE: begin
                if (status.emit_ok) begin
                    state_next = ST_READ;
                end
            end
            ST_NEW: begin
                if (new_go) begin
                    if (status.fin) begin
                        drain_next = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.hold_valid || status.emit_ok) begin
                    drain_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_READ: begin
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
            end
            ST_RETIRE: begin
                cmd.retire = status.emit_ok;
            end
            ST_NEW: begin
                cmd.start_new = new_go && status.new_ok;
                cmd.enqueue   = new_go && !status.new_ok && status.room;
                cmd.drop      = new_go && !status.new_ok && !status.room;
            end
            ST_FLUSH: begin
                cmd.flush = status.hold_valid && status.emit_ok;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/bfss_dpath.sv
// ----------------------------------------------------------------------------
// bfss_dpath
// Queue memory, server clock, finish adder and the two-deep result buffer.
// ----------------------------------------------------------------------------
module bfss_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bfss_pkg::ctrl_cmd_t           cmd,
    output bfss_pkg::dp_status_t          status,
    input  logic [bfss_pkg::TIME_W-1:0]   in_arrival,
    input  logic [bfss_pkg::LEN_W-1:0]    in_len,
    input  logic [bfss_pkg::TAG_W-1:0]    in_tag,
    input  logic                          in_fin,
    input  logic [bfss_pkg::LIMIT_W-1:0]  queue_limit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bfss_pkg::TAG_W-1:0]    m_tag,
    output logic [bfss_pkg::FIN_W-1:0]    m_finish,
    output logic                          m_dropped,
    output logic                          m_last
);
    import bfss_pkg::*;

    // Current item.
    logic [TIME_W-1:0] arrival_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              fin_reg;

    // Server and queue state.
    logic [FIN_W-1:0]  free_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [FIN_W-1:0]  start_reg;
    entry_t            mem_q [QUEUE_DEPTH];
    entry_t            rd_reg;
    logic [PTR_W-1:0]  tail;
    logic [LIMIT_W-1:0] limit_eff;

    // Result buffer: one held result plus the output register.
    logic              hold_valid_reg;
    logic [TAG_W-1:0]  hold_tag_reg;
    logic [FIN_W-1:0]  hold_finish_reg;
    logic              hold_drop_reg;
    logic              out_valid_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [FIN_W-1:0]  out_finish_reg;
    logic              out_drop_reg;
    logic              out_last_reg;

    logic [FIN_W-1:0]  arrival_ext;
    logic [FIN_W-1:0]  head_start;
    logic [FIN_W-1:0]  add_a;
    logic [FIN_W-1:0]  add_b;
    logic [FIN_W:0]    add_sum;
    logic [FIN_W-1:0]  finish_sat;
    logic              emit_new;
    logic              out_free;
    logic [TAG_W-1:0]  new_tag;
    logic [FIN_W-1:0]  new_finish;

    assign arrival_ext = FIN_W'(arrival_reg);
    assign tail        = head_reg + count_reg[PTR_W-1:0];
    assign limit_eff   = (queue_limit > LIMIT_W'(QUEUE_DEPTH)) ?
                         LIMIT_W'(QUEUE_DEPTH) : queue_limit;

    // Start tick of the queued head: no earlier than its arrival or a free server.
    assign head_start = (free_reg > FIN_W'(rd_reg.arrival)) ?
                        free_reg : FIN_W'(rd_reg.arrival);

    // Shared finish adder with saturation.
    assign add_a      = cmd.retire ? start_reg : arrival_ext;
    assign add_b      = cmd.retire ? FIN_W'(rd_reg.len) : FIN_W'(len_reg);
    assign add_sum    = {1'b0, add_a} + {1'b0, add_b};
    assign finish_sat = add_sum[FIN_W] ? FIN_MAX : add_sum[FIN_W-1:0];

    // Result produced this cycle.
    assign emit_new   = cmd.retire || cmd.start_new || cmd.drop;
    assign new_tag    = cmd.retire ? rd_reg.tag : tag_reg;
    assign new_finish = cmd.drop ? '0 : finish_sat;
    assign out_free   = !out_valid_reg || m_ready;

    // Status toward the controller.
    always_comb begin
        status.count_zero = (count_reg == '0);
        status.head_due   = (head_start <= arrival_ext);
        status.new_ok     = (count_reg == '0) && (free_reg <= arrival_ext);
        status.room       = (count_reg < CNT_W'(limit_eff));
        status.emit_ok    = !hold_valid_reg || out_free;
        status.hold_valid = hold_valid_reg;
        status.fin        = fin_reg;
    end

    // Item capture and start tick register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            arrival_reg <= in_arrival;
            len_reg     <= in_len;
            tag_reg     <= in_tag;
            fin_reg     <= in_fin;
        end
        if (cmd.check) begin
            start_reg <= head_start;
        end
    end

    // Queue memory: one write port at the tail, registered read at the head.
    always_ff @(posedge aclk) begin
        if (cmd.enqueue) begin
            mem_q[tail] <= '{tag: tag_reg, len: len_reg, arrival: arrival_reg};
        end
        rd_reg <= mem_q[head_reg];
    end

    // Server clock, head pointer and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg  <= '0;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.retire || cmd.start_new) begin
                free_reg <= finish_sat;
            end
            if (cmd.retire) begin
                head_reg  <= head_reg + PTR_W'(1);
                count_reg <= count_reg - CNT_W'(1);
            end else if (cmd.enqueue) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // Held result: released as not last when another result follows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (emit_new) begin
            hold_valid_reg <= 1'b1;
        end else if (cmd.flush) begin
            hold_valid_reg <= 1'b0;
        end
        if (emit_new) begin
            hold_tag_reg    <= new_tag;
            hold_finish_reg <= new_finish;
            hold_drop_reg   <= cmd.drop;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((emit_new && hold_valid_reg) || cmd.flush) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if ((emit_new && hold_valid_reg) || cmd.flush) begin
            out_tag_reg    <= hold_tag_reg;
            out_finish_reg <= hold_finish_reg;
            out_drop_reg   <= hold_drop_reg;
            out_last_reg   <= cmd.flush;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_tag     = out_tag_reg;
    assign m_finish  = out_finish_reg;
    assign m_dropped = out_drop_reg;
    assign m_last    = out_last_reg;

endmodule

>>> rtl/bounded_fifo_server_scheduler.sv
// ----------------------------------------------------------------------------
// bounded_fifo_server_scheduler
// Single server with a bounded FIFO waiting queue and tail drop.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes the read and check states, a retire and new
// read per retired queued task, then admit and flush, with the queue drained first
// for a final item; output stalls hold retire, admit and flush. Throughput: one
// item at a time, set by the registered queue read and the one shared finish adder.
// Reset: synchronous and active low; clears the server clock, head pointer,
// fill count and sets queue_limit to 32. Queue memory contents are not reset.
module bounded_fifo_server_scheduler (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfss_pkg::APB_A_W-1:0]    paddr,
    input  logic [bfss_pkg::APB_D_W-1:0]    pwdata,
    output logic [bfss_pkg::APB_D_W-1:0]    prdata,
    output logic                            pready,
    // Task items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bfss_pkg::S_DATA_W-1:0]   s_tdata,  // arrival_time, run_length, task_tag
    input  logic                            s_tlast,  // final_task
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bfss_pkg::M_DATA_W-1:0]   m_tdata,  // done_tag, finish tick
    output logic                            m_tuser,  // dropped
    output logic                            m_tlast   // last_of_run
);
    import bfss_pkg::*;

    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic [LIMIT_W-1:0] limit_reg;
    logic [TAG_W-1:0]   out_tag;
    logic [FIN_W-1:0]   out_finish;

    // Configuration register.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == ADDR_QUEUE_LIMIT)) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_QUEUE_LIMIT) ? APB_D_W'(limit_reg) : '0;

    // Controller.
    bfss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    bfss_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_arrival  (s_tdata[TIME_W-1:0]),
        .in_len      (s_tdata[TIME_W+LEN_W-1:TIME_W]),
        .in_tag      (s_tdata[TIME_W+LEN_W+TAG_W-1:TIME_W+LEN_W]),
        .in_fin      (s_tlast),
        .queue_limit (limit_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_tag       (out_tag),
        .m_finish    (out_finish),
        .m_dropped   (m_tuser),
        .m_last      (m_tlast)
    );

    assign m_tdata = {out_finish, out_tag};

endmodule

>>> rtl/bfss_checker.sv
// ----------------------------------------------------------------------------
// bfss_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module bfss_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          pready,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bfss_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import bfss_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A dropped task always reports a zero finish tick.
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[M_DATA_W-1:TAG_W] == '0)
        else $error("dropped result with nonzero finish");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted back to back");

    // Reset empties the output.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The register port never waits.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind bounded_fifo_server_scheduler bfss_checker u_bfss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/tb_bounded_fifo_server_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_fifo_server_scheduler
// Self-checking testbench for the bounded FIFO server scheduler. A behavioral
// copy of the scheduler predicts every result item from the accepted task
// items, and each result leaving the block is compared field by field with
// the oldest prediction. Directed tasks cover immediate starts, queueing,
// tail drop, the limit extremes, a full queue and finish ticks beyond 32 bits.
// Random traffic runs under changing stall patterns and output back-pressure.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_server_scheduler;
    import bfss_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 40;
    localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // One predicted result item.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [FIN_W-1:0] finish_tick;
        logic             dropped;
        logic             last;
    } sched_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_A_W-1:0]  paddr    = '0;
    logic [APB_D_W-1:0]  pwdata   = '0;
    logic [APB_D_W-1:0]  prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // arrival_time, run_length, task_tag
    logic                s_tlast  = 1'b0; // final_task
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // done_tag, finish tick
    logic                m_tuser;        // dropped
    logic                m_tlast;        // last_of_run

    // Scheduler state as predicted by the testbench.
    logic [TIME_W-1:0]  mdl_arrival [QUEUE_DEPTH];
    logic [LEN_W-1:0]   mdl_length  [QUEUE_DEPTH];
    logic [TAG_W-1:0]   mdl_tag     [QUEUE_DEPTH];
    logic [PTR_W-1:0]   mdl_head    = '0;
    logic [CNT_W-1:0]   mdl_count   = '0;
    logic [FIN_W-1:0]   mdl_free_at = '0;
    logic [LIMIT_W-1:0] mdl_limit   = LIMIT_RESET;

    sched_result_t batch_q[$];
    sched_result_t finish_q[$];

    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          hold_request   = 0;
    int          hold_left      = 0;
    logic [TIME_W-1:0] cur_arrival = '0;

    bounded_fifo_server_scheduler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Scheduler prediction
    // ------------------------------------------------------------------------

    function automatic logic [FIN_W-1:0] sat_add(input logic [FIN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [FIN_W:0] sum;
        sum = {1'b0, a} + (FIN_W + 1)'(b);
        return sum[FIN_W] ? FIN_MAX : sum[FIN_W-1:0];
    endfunction

    function automatic sched_result_t make_result(input logic [TAG_W-1:0] tag,
                                                  input logic [FIN_W-1:0] tick,
                                                  input logic drop);
        sched_result_t r;
        r.tag         = tag;
        r.finish_tick = tick;
        r.dropped     = drop;
        r.last        = 1'b0;
        return r;
    endfunction

    // A queued task starts when both it has arrived and the server is free.
    function automatic logic [FIN_W-1:0] head_start_tick();
        logic [FIN_W-1:0] arr;
        arr = FIN_W'(mdl_arrival[mdl_head]);
        return (mdl_free_at > arr) ? mdl_free_at : arr;
    endfunction

    function automatic void retire_head();
        mdl_free_at = sat_add(head_start_tick(), mdl_length[mdl_head]);
        batch_q.push_back(make_result(mdl_tag[mdl_head], mdl_free_at, 1'b0));
        mdl_head  = mdl_head + 1'b1;
        mdl_count = mdl_count - 1'b1;
    endfunction

    // Works out the results of one accepted task and queues them for checking.
    function automatic void predict_schedule(input logic [TIME_W-1:0] arr,
                                             input logic [LEN_W-1:0]  len,
                                             input logic [TAG_W-1:0]  tag,
                                             input logic              is_final);
        logic [CNT_W-1:0] eff_limit;
        logic [PTR_W-1:0] tail;
        sched_result_t    r;
        eff_limit = (mdl_limit > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : mdl_limit;
        batch_q.delete();

        while (mdl_count != 0 && head_start_tick() <= FIN_W'(arr))
            retire_head();

        if (mdl_count == 0 && mdl_free_at <= FIN_W'(arr)) begin
            mdl_free_at = sat_add(FIN_W'(arr), len);
            batch_q.push_back(make_result(tag, mdl_free_at, 1'b0));
        end else if (mdl_count < eff_limit) begin
            tail = mdl_head + mdl_count[PTR_W-1:0];
            mdl_arrival[tail] = arr;
            mdl_length[tail]  = len;
            mdl_tag[tail]     = tag;
            mdl_count         = mdl_count + 1'b1;
        end else begin
            batch_q.push_back(make_result(tag, '0, 1'b1));
        end

        if (is_final)
            while (mdl_count != 0)
                retire_head();

        // The last result of the item carries the end-of-run mark.
        for (int i = 0; i < batch_q.size(); i++) begin
            r      = batch_q[i];
            r.last = (i == batch_q.size() - 1);
            finish_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // Printing is capped so that a broken block cannot flood the log.
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    always @(posedge aclk) begin : result_check
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (finish_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result item, tag %h",
                                          m_tdata[TAG_W-1:0]));
            end else begin
                want = finish_q.pop_front();
                if (m_tdata[TAG_W-1:0] !== want.tag)
                    report_mismatch($sformatf("done_tag %h, expected %h",
                                              m_tdata[TAG_W-1:0], want.tag));
                if (m_tdata[TAG_W +: FIN_W] !== want.finish_tick)
                    report_mismatch($sformatf("finish tick %h, expected %h (tag %h)",
                                              m_tdata[TAG_W +: FIN_W],
                                              want.finish_tick, want.tag));
                if (m_tuser !== want.dropped)
                    report_mismatch($sformatf("dropped %b, expected %b (tag %h)",
                                              m_tuser, want.dropped, want.tag));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b (tag %h)",
                                              m_tlast, want.last, want.tag));
            end
        end
    end

    // The receiver either stalls at random or holds off for a requested stretch.
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Ends the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Offers one task item; entered and left at a falling edge.
    task automatic push_task(input logic [TIME_W-1:0] arr, input logic [LEN_W-1:0] len,
                             input logic [TAG_W-1:0] tag, input logic is_final);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, len, arr};
        s_tlast  <= is_final;
        do @(posedge aclk); while (!s_tready);
        predict_schedule(arr, len, tag, is_final);
        @(negedge aclk);
    endtask

    // Stops offering, waits for every predicted result, then lets the block settle.
    task automatic wait_results_drained(input int settle);
        s_tvalid <= 1'b0;
        while (finish_q.size() != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // One register access: a setup phase and then an access phase.
    task automatic apb_access(input logic wr, input logic [APB_D_W-1:0] wdata,
                              output logic [APB_D_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_QUEUE_LIMIT;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Writes the queue limit while the block is idle and reads it back.
    task automatic set_queue_limit(input logic [LIMIT_W-1:0] value);
        logic [APB_D_W-1:0] rd;
        wait_results_drained(SETTLE_CYCLES);
        apb_access(1'b1, APB_D_W'(value), rd);
        mdl_limit = value;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_D_W'(value))
            report_mismatch($sformatf("queue_limit reads %h, expected %h", rd, value));
    endtask

    // Random task: mostly steady arrivals, some bursts, gaps and late arrivals.
    task automatic push_random_task();
        int unsigned       sel;
        logic [TIME_W-1:0] arr;
        logic [LEN_W-1:0]  len;
        sel = $urandom_range(99);
        if (sel < 50)
            cur_arrival = cur_arrival + $urandom_range(8);
        else if (sel < 85)
            cur_arrival = cur_arrival + $urandom_range(60, 9);
        else if (sel < 97)
            cur_arrival = cur_arrival + $urandom_range(600, 61);
        arr = cur_arrival;
        if (sel >= 97 && cur_arrival > 100)
            arr = cur_arrival - $urandom_range(100, 1);
        len = ($urandom_range(19) == 0) ? $urandom_range(400, 41) : $urandom_range(40, 1);
        push_task(arr, len, TAG_W'($urandom), ($urandom_range(15) == 0));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_register_reset();
        logic [APB_D_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_D_W'(LIMIT_RESET))
            report_mismatch($sformatf("queue_limit after reset %h", rd));
    endtask

    // Immediate start, start at the exact finish tick, queueing, multiple
    // retirements on one arrival, late arrivals and a final drain.
    task automatic test_start_and_queue();
        push_task(32'd0,  32'd1,  16'h0000, 1'b0);
        push_task(32'd1,  32'd10, 16'hFFFF, 1'b0);
        push_task(32'd5,  32'd3,  16'h0002, 1'b0);
        push_task(32'd5,  32'd2,  16'h0003, 1'b0);
        push_task(32'd30, 32'd4,  16'h0004, 1'b0);
        push_task(32'd20, 32'd5,  16'h0005, 1'b0);
        push_task(32'd20, 32'd1,  16'h0006, 1'b1);
    endtask

    // A limit of one drops the second waiting task; a limit of zero drops
    // every task that cannot start at once, even a final one.
    task automatic test_limit_extremes();
        set_queue_limit(6'd1);
        push_task(32'd100, 32'd50, 16'h0100, 1'b0);
        push_task(32'd110, 32'd5,  16'h0101, 1'b0);
        push_task(32'd120, 32'd5,  16'h0102, 1'b0);
        push_task(32'd160, 32'd1,  16'h0103, 1'b0);
        set_queue_limit(6'd0);
        push_task(32'd170, 32'd20, 16'h0104, 1'b0);
        push_task(32'd175, 32'd1,  16'h0105, 1'b0);
        push_task(32'd180, 32'd1,  16'h0106, 1'b1);
        push_task(32'd190, 32'd1,  16'h0107, 1'b0);
    endtask

    // A limit above the depth acts as the depth: the first task keeps the
    // server busy past every later arrival, so 32 tasks wait, the next one
    // is dropped and its final mark drains the whole queue in one run.
    task automatic test_queue_overflow();
        set_queue_limit(6'd63);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_task(32'd300, 32'd100, 16'h0200, 1'b0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            push_task(32'd301 + i[TIME_W-1:0], $urandom_range(15, 1),
                      TAG_W'($urandom), 1'b0);
        push_task(32'd340, 32'd1, 16'h02FF, 1'b1);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [LIMIT_W-1:0] limit, input int count);
        set_queue_limit(limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        cur_arrival   = mdl_free_at[TIME_W-1:0] + 32'd5;
        for (int i = 0; i < count; i++)
            push_random_task();
        push_task(cur_arrival + 32'd1000, 32'd1, TAG_W'($urandom), 1'b1);
    endtask

    // The receiver holds off while tasks keep coming, so the block fills and
    // stalls its input; then the sender waits for every result to arrive.
    task automatic test_output_backpressure();
        set_queue_limit(6'd8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cur_arrival   = mdl_free_at[TIME_W-1:0] + 32'd5;
        hold_request  = HOLD_CYCLES;
        for (int i = 0; i < 48; i++)
            push_random_task();
        wait_results_drained(0);
        for (int i = 0; i < 16; i++)
            push_random_task();
        push_task(cur_arrival + 32'd1000, 32'd1, TAG_W'($urandom), 1'b1);
    endtask

    // Longest tasks are chained through the queue so that finish ticks carry
    // well past 32 bits. The server stays busy past any arrival afterwards,
    // so this test runs last.
    task automatic test_long_finish();
        set_queue_limit(6'd32);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_task(TIME_MAX, LEN_MAX, 16'hFFFF, 1'b0);
        for (int i = 0; i < 4; i++)
            push_task('0, LEN_MAX, TAG_W'($urandom), 1'b0);
        push_task(TIME_MAX, 32'd1, 16'h0301, 1'b1);
        push_task('0, 32'd1, 16'h0302, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        send_idle_pct = 19;
        recv_idle_pct = 70;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_register_reset();
        test_start_and_queue();
        test_limit_extremes();
        test_queue_overflow();
        test_random_traffic(19, 70, 6'd4, 86);
        test_random_traffic(70, 19, 6'd2, 86);
        test_random_traffic(0, 0, 6'd32, 86);
        test_output_backpressure();
        test_long_finish();

        wait_results_drained(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
